// ===== sv/scr_pkg.sv =====
// shared types and constants of the sector cache clock replacement unit
package scr_pkg;

  localparam int LINES = 64;
  localparam int LINE_W = 6;
  localparam int CNT_W = LINE_W + 1;
  localparam int SECTOR_W = 32;

  typedef struct packed {
    logic                action;
    logic [SECTOR_W-1:0] sector;
    logic                meta_flag;
    logic                write_flag;
  } in_t;

  typedef struct packed {
    logic                hit;
    logic [LINE_W-1:0]   line;
    logic                writeback_valid;
    logic [SECTOR_W-1:0] writeback_sector;
    logic                fill_valid;
    logic                last;
  } out_t;

  typedef struct packed {
    logic                flush;
    logic [SECTOR_W-1:0] sector;
    logic                meta;
    logic                wr;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_VREAD,
    ST_VTAG,
    ST_FLUSH,
    ST_FREAD,
    ST_EMIT
  } state_t;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

endpackage

// ===== sv/scr_front.sv =====
// input queue that accepts items and classifies them into jobs
module scr_front import scr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic job_valid,
  output job_t job,
  input  logic job_take
);

  job_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  job_t       cls;

  always_comb begin
    cls.flush  = (item.action == ACT_FLUSH);
    cls.sector = item.sector;
    cls.meta   = item.meta_flag;
    cls.wr     = item.write_flag;
  end

  assign full      = (count == 2'd2);
  assign job_valid = (count != 2'd0);
  assign job       = slot[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) wptr <= ~wptr;
      if (job_take && job_valid) rptr <= ~rptr;
      count <= count + {1'b0, (push && !full)} - {1'b0, (job_take && job_valid)};
    end
  end

endmodule

// ===== sv/scr_outq.sv =====
// result queue between the engine and the result port
module scr_outq import scr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_push,
  input  out_t res,
  output logic res_full,
  output logic empty,
  input  logic pop,
  output out_t result
);

  out_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign result   = slot[rptr];

  always_ff @(posedge clk) begin
    if (res_push && !res_full) begin
      slot[wptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (res_push && !res_full) wptr <= ~wptr;
      if (pop && !empty) rptr <= ~rptr;
      count <= count + {1'b0, (res_push && !res_full)} - {1'b0, (pop && !empty)};
    end
  end

endmodule

// ===== sv/scr_back.sv =====
// tag lookup, clock victim scan and flush engine
module scr_back import scr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  job_t job,
  output logic job_take,
  output logic res_push,
  output out_t res,
  input  logic res_full
);

  state_t state, state_next;
  state_t ret_state;
  job_t   cur;

  logic [SECTOR_W-1:0] tag_mem [LINES];
  logic [SECTOR_W-1:0] tag_q;
  logic [LINE_W-1:0]   raddr;

  logic [LINES-1:0] valid;
  logic [LINES-1:0] acc;
  logic [LINES-1:0] meta;
  logic [LINES-1:0] dirty;

  logic [CNT_W-1:0]  look_cnt;
  logic              cmp_v;
  logic [LINE_W-1:0] cmp_idx;
  logic [LINE_W-1:0] pos;
  logic [LINE_W-1:0] turn;
  logic [LINE_W-1:0] start;
  logic [LINE_W-1:0] hand;
  logic [LINE_W-1:0] vline;
  logic              found;

  logic              match;
  logic              last_cmp;
  logic              pick;
  logic [LINE_W-1:0] pos_inc;
  logic [LINE_W-1:0] hand_inc;
  logic [LINES-1:0]  dirty_vec;
  logic              rem_here;
  logic              rem_above;

  assign match    = cmp_v && valid[cmp_idx] && (tag_q == cur.sector);
  assign last_cmp = cmp_v && (cmp_idx == LINE_W'(LINES - 1));
  assign pos_inc  = (pos == LINE_W'(LINES - 1)) ? '0 : pos + 1'b1;
  assign hand_inc = (hand == LINE_W'(LINES - 1)) ? '0 : hand + 1'b1;
  assign pick     = (!acc[pos] && !meta[pos]) || (turn == LINE_W'(LINES - 1));
  assign dirty_vec = valid & dirty;
  assign rem_here  = |(dirty_vec >> pos);
  assign rem_above = |((dirty_vec >> pos) >> 1);

  always_comb begin
    raddr = look_cnt[LINE_W-1:0];
    unique case (state)
      ST_VREAD: raddr = vline;
      ST_FLUSH: raddr = pos;
      default:  raddr = look_cnt[LINE_W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    tag_q <= tag_mem[raddr];
    if (state == ST_VTAG) begin
      tag_mem[vline] <= cur.sector;
    end
  end

  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (job_valid) begin
          job_take   = 1'b1;
          state_next = job.flush ? ST_FLUSH : ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (match) state_next = ST_EMIT;
        else if (last_cmp) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (pick) state_next = ST_VREAD;
      end
      ST_VREAD: state_next = ST_VTAG;
      ST_VTAG:  state_next = ST_EMIT;
      ST_FLUSH: begin
        if (dirty_vec[pos]) state_next = ST_FREAD;
        else if (!rem_here) state_next = found ? ST_IDLE : ST_EMIT;
      end
      ST_FREAD: state_next = ST_EMIT;
      ST_EMIT: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = ret_state;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      acc   <= '0;
      meta  <= '0;
      dirty <= '0;
      hand  <= LINE_W'(LINES - 1);
      cmp_v <= 1'b0;
      found <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) cur <= job;
          look_cnt <= '0;
          cmp_v    <= 1'b0;
          pos      <= '0;
          found    <= 1'b0;
        end
        ST_LOOK: begin
          cmp_v    <= (look_cnt < CNT_W'(LINES));
          cmp_idx  <= look_cnt[LINE_W-1:0];
          look_cnt <= look_cnt + 1'b1;
          if (match) begin
            acc[cmp_idx] <= 1'b1;
            if (cur.meta) meta[cmp_idx] <= 1'b1;
            if (cur.wr) dirty[cmp_idx] <= 1'b1;
            res       <= '{hit: 1'b1, line: cmp_idx, writeback_valid: 1'b0,
                           writeback_sector: '0, fill_valid: 1'b0, last: 1'b1};
            ret_state <= ST_IDLE;
          end else if (last_cmp) begin
            pos   <= hand_inc;
            start <= hand_inc;
            turn  <= '0;
          end
        end
        ST_SCAN: begin
          if (acc[pos]) acc[pos] <= 1'b0;
          else if (meta[pos]) meta[pos] <= 1'b0;
          if (pick) begin
            vline <= (!acc[pos] && !meta[pos]) ? pos : start;
          end
          pos  <= pos_inc;
          turn <= turn + 1'b1;
        end
        ST_VTAG: begin
          res <= '{hit: 1'b0, line: vline,
                   writeback_valid: valid[vline] && dirty[vline],
                   writeback_sector: (valid[vline] && dirty[vline]) ? tag_q : '0,
                   fill_valid: 1'b1, last: 1'b1};
          valid[vline] <= 1'b1;
          acc[vline]   <= 1'b1;
          meta[vline]  <= cur.meta;
          dirty[vline] <= cur.wr;
          hand         <= vline;
          ret_state    <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (!dirty_vec[pos] && rem_here) begin
            pos <= pos_inc;
          end else if (!dirty_vec[pos]) begin
            res       <= '{hit: 1'b0, line: '0, writeback_valid: 1'b0,
                           writeback_sector: '0, fill_valid: 1'b0, last: 1'b1};
            ret_state <= ST_IDLE;
          end
        end
        ST_FREAD: begin
          res        <= '{hit: 1'b0, line: pos, writeback_valid: 1'b1,
                          writeback_sector: tag_q, fill_valid: 1'b0, last: !rem_above};
          ret_state  <= rem_above ? ST_FLUSH : ST_IDLE;
          dirty[pos] <= 1'b0;
          found      <= 1'b1;
        end
        ST_EMIT: begin
          if (!res_full && ret_state == ST_FLUSH) pos <= pos_inc;
        end
        default: begin
          cmp_v <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/sector_cache_clock_replacement_unit.sv =====
// top level of the sector cache clock replacement unit
//
// items enter through push/full: an access (sector, metadata and write flags)
// or a flush. results leave through empty/pop, oldest first, with last set on
// the final result of each item.
// an access looks its sector up one line per cycle against the tag memory,
// stopping at the first match; a hit then gives one result. a miss walks the
// clock hand one line per cycle until it finds a victim, reads the victim's
// old tag in the VREAD and VTAG states and gives one result.
// a flush walks the lines one per cycle, stopping at each dirty line for the
// FREAD and EMIT states (EMIT waits while the result queue is full), and gives
// one writeback result for each dirty line, or one empty result if none.
// the tag lookup and the serial walk set the rate: one item is worked on at a
// time.
// two-entry queues stand on both sides, so items are taken while a result
// waits; when pop stays low the engine holds its result and stops.
// reset (synchronous, rst high) empties both queues, clears all line valid
// and mark bits and sets the clock hand to the last line; tags need no reset.
module sector_cache_clock_replacement_unit import scr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  logic job_valid;
  job_t job;
  logic job_take;
  logic res_push;
  out_t res;
  logic res_full;

  scr_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .job_valid(job_valid), .job(job), .job_take(job_take)
  );

  scr_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_take(job_take),
    .res_push(res_push), .res(res), .res_full(res_full)
  );

  scr_outq u_outq (
    .clk(clk), .rst(rst), .res_push(res_push), .res(res), .res_full(res_full),
    .empty(empty), .pop(pop), .result(result)
  );

endmodule

// ===== sv/scr_checker.sv =====
// port checker for the sector cache clock replacement unit
module scr_checker import scr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic push,
  input logic full,
  input in_t  item,
  input logic empty,
  input logic pop,
  input out_t result
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not empty after reset");

  a_hit_alone: assert property (@(posedge clk) disable iff (rst)
    !empty && result.hit |-> !result.writeback_valid && !result.fill_valid && result.last)
    else $error("hit result malformed");

  a_fill_last: assert property (@(posedge clk) disable iff (rst)
    !empty && result.fill_valid |-> !result.hit && result.last)
    else $error("fill result malformed");

  a_bare_last: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.writeback_valid && !result.fill_valid |-> result.last)
    else $error("result without action not last");

  a_wb_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !result.writeback_valid |-> result.writeback_sector == '0)
    else $error("writeback sector without writeback");

endmodule

bind sector_cache_clock_replacement_unit scr_checker u_scr_checker (.*);

// ===== tb/sv/sector_cache_clock_replacement_unit_tb.sv =====
// testbench of the sector cache clock replacement unit: predicted results checked in order
module sector_cache_clock_replacement_unit_tb;
  import scr_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  in_t  item = '0;
  logic empty;
  logic pop = 1'b0;
  out_t result;

  sector_cache_clock_replacement_unit dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .item(item),
    .empty(empty), .pop(pop), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [SECTOR_W-1:0] tag_mem [LINES];
  logic                valid_mem [LINES];
  logic                acc_mark [LINES];
  logic                meta_mark [LINES];
  logic                dirty_mark [LINES];
  logic [LINE_W-1:0]   hand;

  in_t  pending_items [$];
  out_t expected_results [$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   quiet_cycles = 0;
  logic [SECTOR_W-1:0] recent [$];

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void predict_cache(input in_t it);
    out_t r;
    int   k;
    int   v;
    int   p;
    int   found;
    bit   done;
    if (it.action == ACT_FLUSH) begin
      k = 0;
      for (int i = 0; i < LINES; i++) begin
        if (valid_mem[i] && dirty_mark[i]) begin
          r = '0;
          r.line = LINE_W'(i);
          r.writeback_valid = 1'b1;
          r.writeback_sector = tag_mem[i];
          expected_results.push_back(r);
          dirty_mark[i] = 1'b0;
          k++;
        end
      end
      if (k == 0) begin
        r = '0;
        r.last = 1'b1;
        expected_results.push_back(r);
      end else begin
        r = expected_results.pop_back();
        r.last = 1'b1;
        expected_results.push_back(r);
      end
      return;
    end
    found = -1;
    for (int i = LINES - 1; i >= 0; i--)
      if (valid_mem[i] && tag_mem[i] == it.sector) found = i;
    r = '0;
    r.last = 1'b1;
    if (found >= 0) begin
      r.hit = 1'b1;
      r.line = LINE_W'(found);
    end else begin
      p = (int'(hand) + 1) % LINES;
      v = p;
      done = 0;
      for (int n = 0; n < LINES && !done; n++) begin
        if (acc_mark[p]) acc_mark[p] = 1'b0;
        else if (meta_mark[p]) meta_mark[p] = 1'b0;
        else begin
          v = p;
          done = 1;
        end
        p = (p + 1) % LINES;
      end
      r.line = LINE_W'(v);
      r.fill_valid = 1'b1;
      if (valid_mem[v] && dirty_mark[v]) begin
        r.writeback_valid = 1'b1;
        r.writeback_sector = tag_mem[v];
      end
      hand = LINE_W'(v);
      tag_mem[v] = it.sector;
      valid_mem[v] = 1'b1;
      acc_mark[v] = 1'b0;
      meta_mark[v] = 1'b0;
      dirty_mark[v] = 1'b0;
      found = v;
    end
    expected_results.push_back(r);
    acc_mark[found] = 1'b1;
    if (it.meta_flag) meta_mark[found] = 1'b1;
    if (it.write_flag) dirty_mark[found] = 1'b1;
  endfunction

  function automatic in_t rand_item();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    return in_t'(rnd[$bits(in_t)-1:0]);
  endfunction

  function automatic in_t make_access(input logic [SECTOR_W-1:0] s, input logic m,
                                      input logic w);
    in_t it;
    it.action = ACT_ACCESS;
    it.sector = s;
    it.meta_flag = m;
    it.write_flag = w;
    return it;
  endfunction

  function automatic in_t make_flush();
    in_t it;
    it = rand_item();
    it.action = ACT_FLUSH;
    return it;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (pending_items.size() > 0 && ($urandom_range(99) >= send_idle)) begin
        push <= 1'b1;
        item <= pending_items[0];
      end else begin
        push <= 1'b0;
        item <= rand_item();
      end
      pop <= ($urandom_range(99) >= recv_stall);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        predict_cache(item);
        void'(pending_items.pop_front());
      end
      if (pop && !empty) begin
        out_t e;
        if (expected_results.size() == 0) begin
          report($sformatf("unexpected result %h", result));
        end else begin
          e = expected_results.pop_front();
          if (result.hit !== e.hit)
            report($sformatf("hit %b exp %b", result.hit, e.hit));
          if (result.line !== e.line)
            report($sformatf("line %0d exp %0d", result.line, e.line));
          if (result.writeback_valid !== e.writeback_valid)
            report($sformatf("writeback_valid %b exp %b", result.writeback_valid,
                             e.writeback_valid));
          if (result.writeback_sector !== e.writeback_sector)
            report($sformatf("writeback_sector %h exp %h", result.writeback_sector,
                             e.writeback_sector));
          if (result.fill_valid !== e.fill_valid)
            report($sformatf("fill_valid %b exp %b", result.fill_valid, e.fill_valid));
          if (result.last !== e.last)
            report($sformatf("last %b exp %b", result.last, e.last));
        end
      end
      if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || push) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
  endtask

  initial begin
    logic [SECTOR_W-1:0] s;
    int r;
    for (int i = 0; i < LINES; i++) begin
      tag_mem[i] = '0;
      valid_mem[i] = 1'b0;
      acc_mark[i] = 1'b0;
      meta_mark[i] = 1'b0;
      dirty_mark[i] = 1'b0;
    end
    hand = LINE_W'(LINES - 1);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty flush, extremes, hits, metadata, writes, flush
    pending_items.push_back(make_flush());
    pending_items.push_back(make_access('0, 1'b0, 1'b0));
    pending_items.push_back(make_access('1, 1'b1, 1'b1));
    pending_items.push_back(make_access('0, 1'b1, 1'b1));
    pending_items.push_back(make_access('1, 1'b0, 1'b0));
    pending_items.push_back(make_access(32'h5555_5555, 1'b0, 1'b1));
    pending_items.push_back(make_access(32'hAAAA_AAAA, 1'b1, 1'b0));
    pending_items.push_back(make_flush());
    pending_items.push_back(make_flush());
    pending_items.push_back(make_access(32'h5555_5555, 1'b1, 1'b1));
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? 81 : (ph == 2 ? 0 : 0);
      recv_stall = (ph == 2 || ph == 3) ? 81 : 0;
      if (ph == 3) begin
        send_idle = 9;
        recv_stall = 9;
      end
      // fills beyond capacity, writebacks, evictions with mixed marks
      for (int n = 0; n < 90; n++) begin
        r = $urandom_range(99);
        if (r < 6) begin
          pending_items.push_back(make_flush());
        end else begin
          if (r < 45 && recent.size() > 0) s = recent[$urandom_range(recent.size() - 1)];
          else if (r < 55) s = $urandom;
          else s = $urandom_range(99);
          recent.push_back(s);
          if (recent.size() > 80) void'(recent.pop_front());
          pending_items.push_back(make_access(s, 1'($urandom_range(1)),
                                              1'($urandom_range(1))));
        end
      end
      pending_items.push_back(make_flush());
      wait_drained();
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
